FILE: rtl/bcl_pkg.sv
// Shared types and constants for the button click and long press detector.
package bcl_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int CFG_WIDTH   = 16;
	localparam int IDX_WIDTH   = 2;

	localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd5;
	localparam logic [CFG_WIDTH-1:0] LONG_RESET     = 16'd20;
	localparam logic [CFG_WIDTH-1:0] WINDOW_RESET   = 16'd30;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_LONG   = 2'd1,
		EV_CLICK  = 2'd2,
		EV_DOUBLE = 2'd3
	} event_t;

	typedef enum logic [IDX_WIDTH-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_LONG     = 2'd1,
		REG_WINDOW   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_WIDTH-1:0] debounce_threshold;
		logic [CFG_WIDTH-1:0] long_threshold;
		logic [CFG_WIDTH-1:0] click_window;
	} cfg_t;

endpackage

FILE: rtl/button_click_long_press_detector.sv
// Top level: input register, tick logic and result register with handshakes.
// An accepted input is held in the input register s1, and its result is then registered in the result register.
// Throughput: one tick per cycle while no result is stalled; the tick logic updates all state in one pass.
// The input stalls only while a result waits in the output register and the sink stalls.
// Reset (arst_n low, asynchronous) clears the valid flags and tick state and loads registers to 5, 20 and 30.
module button_click_long_press_detector import bcl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 button_level,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           event_code,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [IDX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0] cfg_data
);

	cfg_t   cfg;
	event_t ev;
	logic   valid_s1;
	logic   level_s1;
	logic   out_valid_q;
	event_t event_q;
	logic   advance;
	logic   step;

	// s1 moves on when the result register is empty or being drained
	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	bcl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bcl_tick u_tick (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.button_level (level_s1),
		.cfg          (cfg),
		.ev           (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) level_s1 <= button_level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) event_q <= ev;
	end

	assign out_valid  = out_valid_q;
	assign event_code = event_q;

	a_accept_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted transaction missing from input register");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(event_q))
		else $error("stalled result changed or dropped");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q && out_stall)
		else $error("input stalled while result register could drain");

endmodule

FILE: rtl/bcl_cfg_regs.sv
// Configuration register file for the detector.
module bcl_cfg_regs import bcl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [IDX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0] cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_threshold <= DEBOUNCE_RESET;
			cfg_q.long_threshold     <= LONG_RESET;
			cfg_q.click_window       <= WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEBOUNCE: cfg_q.debounce_threshold <= cfg_data;
				REG_LONG:     cfg_q.long_threshold     <= cfg_data;
				REG_WINDOW:   cfg_q.click_window       <= cfg_data;
				default:      ;
			endcase
		end
	end

endmodule

FILE: rtl/bcl_tick.sv
// Per-tick debounce, hold counter and click timer state with its update logic.
module bcl_tick import bcl_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   step,
	input  logic   button_level,
	input  cfg_t   cfg,
	output event_t ev
);

	localparam logic [COUNT_WIDTH-1:0] HELD_MAX  = '1;
	localparam logic [15:0]            CNT_MAX   = '1;
	localparam int                     CMP_WIDTH = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

	logic [15:0]            integrator_q;
	logic                   debounced_q;
	logic [COUNT_WIDTH-1:0] held_ticks_q;
	logic                   before_q;
	logic [15:0]            release_count_q;
	logic [15:0]            release_timer_q;

	logic [15:0]            integ_n;
	logic                   deb_n;
	logic [COUNT_WIDTH-1:0] held_inc;
	logic [COUNT_WIDTH-1:0] held_n;
	logic                   before_n;
	logic [15:0]            count_n;
	logic [15:0]            timer_n;
	logic [CMP_WIDTH-1:0]   long_thr;
	logic [CMP_WIDTH-1:0]   held_cmp;
	logic                   long_hit;
	logic                   falling;
	logic                   click_ret;
	event_t                 ev_n;

	// compare hold count and threshold at the wider of the two widths
	assign long_thr = CMP_WIDTH'(cfg.long_threshold);

	always_comb begin
		logic [15:0] cnt_tmp;
		logic [15:0] tmr_tmp;
		integ_n   = integrator_q;
		deb_n     = debounced_q;
		before_n  = before_q;
		count_n   = release_count_q;
		timer_n   = release_timer_q;
		ev_n      = EV_NONE;
		falling   = 1'b0;
		click_ret = 1'b0;
		cnt_tmp   = release_count_q;
		tmr_tmp   = release_timer_q;

		// up/down integrator, low level means pressed
		if (!button_level) begin
			if (integrator_q < cfg.debounce_threshold) integ_n = integrator_q + 16'd1;
			else deb_n = 1'b1;
		end else begin
			if (integrator_q != 16'd0) integ_n = integrator_q - 16'd1;
			else deb_n = 1'b0;
		end

		held_inc = (deb_n && held_ticks_q != HELD_MAX) ? held_ticks_q + 1'b1 : held_ticks_q;
		held_cmp = CMP_WIDTH'(held_inc);
		long_hit = deb_n && (held_cmp >= long_thr);
		held_n   = held_inc;

		if (long_hit) begin
			// long press ends the tick: edge tracking and timer stay put
			ev_n = EV_LONG;
		end else begin
			falling  = !deb_n && before_q;
			before_n = deb_n;
			if (falling && held_cmp < long_thr) begin
				if (cnt_tmp != CNT_MAX) cnt_tmp = cnt_tmp + 16'd1;
				tmr_tmp = 16'd0;
			end
			if (tmr_tmp != CNT_MAX) tmr_tmp = tmr_tmp + 16'd1;
			timer_n = tmr_tmp;
			count_n = cnt_tmp;
			if (tmr_tmp == cfg.click_window) begin
				count_n = 16'd0;
				if (cnt_tmp == 16'd1) begin
					ev_n      = EV_CLICK;
					click_ret = 1'b1;
				end else if (cnt_tmp == 16'd2) begin
					ev_n      = EV_DOUBLE;
					click_ret = 1'b1;
				end
			end
			if (!deb_n && !click_ret) held_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integrator_q    <= '0;
			debounced_q     <= 1'b0;
			held_ticks_q    <= '0;
			before_q        <= 1'b0;
			release_count_q <= '0;
			release_timer_q <= '0;
		end else if (step) begin
			integrator_q    <= integ_n;
			debounced_q     <= deb_n;
			held_ticks_q    <= held_n;
			before_q        <= before_n;
			release_count_q <= count_n;
			release_timer_q <= timer_n;
		end
	end

	assign ev = ev_n;

	a_long_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		step && ev_n == EV_LONG |=> debounced_q)
		else $error("long press reported while debounced state is released");

	a_long_timer_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		step && ev_n == EV_LONG |=> $stable(release_timer_q) && $stable(before_q))
		else $error("timer or edge tracker moved on a long press tick");

	a_click_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && (ev_n == EV_CLICK || ev_n == EV_DOUBLE) |=> release_count_q == 16'd0)
		else $error("release count not cleared after click event");

endmodule

FILE: sim/tb.sv
// Testbench for the button click and long press detector: directed table, random gestures, then a full-scale run.
module tb;
	import bcl_pkg::*;

	localparam logic [IDX_WIDTH-1:0] REG_UNUSED = 2'd3;
	localparam int TICK_PERIOD = 20;
	localparam int IDLE_PCT    = 23;
	localparam int PHASE_TICKS = 90;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [IDX_WIDTH-1:0] idx;
		logic [CFG_WIDTH-1:0] data;
		logic                 level;
		logic                 typed;   // expectation given in the row itself
		event_t               want;
	} row_t;

	localparam int N_ROWS = 32;
	localparam row_t SCRIPT [N_ROWS] = '{
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b1, 1'b1, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b0, 1'b1, EV_NONE},
		// zero debounce and zero long threshold: any held tick is a long press
		'{ROW_WRITE, REG_DEBOUNCE, 16'd0,     1'b1, 1'b0, EV_NONE},
		'{ROW_WRITE, REG_LONG,     16'd0,     1'b1, 1'b0, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b0, 1'b1, EV_LONG},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b0, 1'b1, EV_LONG},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b1, 1'b0, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b1, 1'b0, EV_NONE},
		// window of one: click lands on the release tick itself
		'{ROW_WRITE, REG_LONG,     16'hFFFF,  1'b1, 1'b0, EV_NONE},
		'{ROW_WRITE, REG_WINDOW,   16'd1,     1'b1, 1'b0, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b0, 1'b0, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b1, 1'b0, EV_NONE},
		// zero window never judges; write to the unused index is dropped
		'{ROW_WRITE, REG_WINDOW,   16'd0,     1'b1, 1'b0, EV_NONE},
		'{ROW_WRITE, REG_UNUSED,   16'hFFFF,  1'b1, 1'b0, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b0, 1'b1, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b1, 1'b1, EV_NONE},
		// second release then double click; then three releases cleared silently
		'{ROW_WRITE, REG_WINDOW,   16'd3,     1'b1, 1'b0, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b0, 1'b0, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b1, 1'b0, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b1, 1'b0, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b1, 1'b0, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b0, 1'b0, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b1, 1'b0, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b0, 1'b0, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b1, 1'b0, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b0, 1'b0, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b1, 1'b0, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b1, 1'b0, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b1, 1'b0, EV_NONE},
		// full-scale debounce: a pressed tick only nudges the integrator
		'{ROW_WRITE, REG_DEBOUNCE, 16'hFFFF,  1'b1, 1'b0, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b0, 1'b1, EV_NONE},
		'{ROW_TICK,  REG_DEBOUNCE, 16'd0,     1'b1, 1'b1, EV_NONE}
	};

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic                 button_level = 1'b1;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	logic [1:0]           event_code;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [IDX_WIDTH-1:0] cfg_index    = '0;
	logic [CFG_WIDTH-1:0] cfg_data     = '0;

	// predictor copy of registers and tick state
	logic [CFG_WIDTH-1:0]   cfg_debounce  = DEBOUNCE_RESET;
	logic [CFG_WIDTH-1:0]   cfg_long      = LONG_RESET;
	logic [CFG_WIDTH-1:0]   cfg_window    = WINDOW_RESET;
	logic [15:0]            integ_level   = '0;
	logic                   is_pressed    = 1'b0;
	logic [COUNT_WIDTH-1:0] held_count    = '0;
	logic                   was_pressed   = 1'b0;
	logic [15:0]            release_tally = '0;
	logic [15:0]            release_age   = '0;

	event_t pending_events [$];
	logic   calm = 1'b0;
	int     ticks_sent, results_seen, mismatches, settings_tried;
	int     tally_long, tally_click, tally_double;

	button_click_long_press_detector uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.button_level (button_level),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.event_code   (event_code),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #(TICK_PERIOD / 2) clk = ~clk;
	end

	function automatic event_t debounce_tick(input logic level);
		logic falling;
		if (!level) begin
			if (integ_level < cfg_debounce)
				integ_level = integ_level + 1'b1;
			else
				is_pressed = 1'b1;
		end else begin
			if (integ_level != '0)
				integ_level = integ_level - 1'b1;
			else
				is_pressed = 1'b0;
		end
		if (is_pressed && held_count != '1)
			held_count = held_count + 1'b1;
		// long press ends the tick before edge and timer work
		if (is_pressed && held_count >= cfg_long)
			return EV_LONG;
		falling = !is_pressed && was_pressed;
		was_pressed = is_pressed;
		if (falling && held_count < cfg_long) begin
			if (release_tally != 16'hFFFF)
				release_tally = release_tally + 1'b1;
			release_age = '0;
		end
		if (release_age != 16'hFFFF)
			release_age = release_age + 1'b1;
		if (release_age == cfg_window) begin
			if (release_tally == 16'd1) begin
				release_tally = '0;
				return EV_CLICK;
			end
			if (release_tally == 16'd2) begin
				release_tally = '0;
				return EV_DOUBLE;
			end
			release_tally = '0;
		end
		if (!is_pressed)
			held_count = '0;
		return EV_NONE;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 40)
			$display("MISMATCH at %0t: %s", $time, msg);
	endtask

	// leaves cfg_valid high so back-to-back writes need one assignment per step
	task automatic write_reg(input logic [IDX_WIDTH-1:0] idx, input logic [CFG_WIDTH-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_DEBOUNCE: cfg_debounce = data;
			REG_LONG:     cfg_long     = data;
			REG_WINDOW:   cfg_window   = data;
			default:      ;
		endcase
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_events.size() != 0);
	endtask

	task automatic send_tick(input logic level, input logic typed, input event_t want);
		event_t predicted;
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		button_level <= level;
		do @(posedge clk); while (in_stall);
		predicted = debounce_tick(level);
		pending_events.push_back(typed ? want : predicted);
		ticks_sent++;
	endtask

	// bounce_pct flips individual ticks; 50 gives pure noise
	task automatic send_run(input logic level, input int count, input int bounce_pct);
		int k;
		for (k = 0; k < count; k++)
			send_tick(level ^ ($urandom_range(99) < bounce_pct), 1'b0, EV_NONE);
	endtask

	task automatic gesture_phase(input int budget);
		int stop, deb, lng, win, pick, reps, r;
		stop = ticks_sent + budget;
		deb  = int'(cfg_debounce);
		lng  = int'(cfg_long);
		win  = int'(cfg_window);
		while (ticks_sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				// quick taps, then a quiet gap past the window
				reps = $urandom_range(1, 3);
				for (r = 0; r < reps; r++) begin
					send_run(1'b0, deb + $urandom_range(1, 3), 3);
					send_run(1'b1, deb + $urandom_range(1, 3), 3);
				end
				send_run(1'b1, deb + win + $urandom_range(1, 6), 3);
			end else if (pick < 70) begin
				send_run(1'b0, deb + $urandom_range(1, lng + 6), 4);
				send_run(1'b1, deb + $urandom_range(1, win + 6), 4);
			end else if (pick < 85) begin
				send_run(1'b1, $urandom_range(1, 6), 50);
			end else if (pick < 87) begin
				drain_results();
			end else begin
				// press that may be too short to get through the debounce
				send_run(1'b0, $urandom_range(1, deb + 1), 0);
				send_run(1'b1, deb + $urandom_range(1, 4), 0);
			end
		end
	endtask

	always @(posedge clk) begin : result_check
		event_t want;
		if (out_valid && !out_stall) begin
			results_seen++;
			if (pending_events.size() == 0) begin
				report_mismatch($sformatf("result %0d (code %0d) with nothing pending",
					results_seen, event_code));
			end else begin
				want = pending_events.pop_front();
				if (event_code !== want)
					report_mismatch($sformatf("result %0d: event_code %0d, expected %0d",
						results_seen, event_code, want));
			end
			case (event_code)
				EV_LONG:   tally_long++;
				EV_CLICK:  tally_click++;
				EV_DOUBLE: tally_double++;
				default:   ;
			endcase
		end
		out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
	end

	initial begin : stimulus
		int i, phase, d, l, w, k;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (i = 0; i < N_ROWS; i++) begin
			if (SCRIPT[i].kind == ROW_WRITE) begin
				if (i == 0 || SCRIPT[i-1].kind != ROW_WRITE)
					drain_results();
				write_reg(SCRIPT[i].idx, SCRIPT[i].data);
				if (i == N_ROWS - 1 || SCRIPT[i+1].kind != ROW_WRITE) begin
					cfg_valid <= 1'b0;
					settings_tried++;
				end
			end else begin
				send_tick(SCRIPT[i].level, SCRIPT[i].typed, SCRIPT[i].want);
			end
		end

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					d = 5; l = 20; w = 30;
				end
				1: begin
					d = $urandom_range(0, 3); l = $urandom_range(1, 10); w = $urandom_range(1, 15);
				end
				2: begin
					d = $urandom_range(1, 4); l = 0; w = $urandom_range(4, 25);
				end
				default: begin
					d = $urandom_range(0, 8); l = $urandom_range(1, 30); w = $urandom_range(1, 40);
				end
			endcase
			drain_results();
			calm = (phase == 3);
			write_reg(REG_DEBOUNCE, CFG_WIDTH'(d));
			write_reg(REG_LONG, CFG_WIDTH'(l));
			write_reg(REG_WINDOW, CFG_WIDTH'(w));
			cfg_valid <= 1'b0;
			settings_tried++;
			gesture_phase(PHASE_TICKS);
		end
		calm = 1'b0;

		// full-scale long threshold and window: long holds and gaps stay silent
		drain_results();
		write_reg(REG_DEBOUNCE, '0);
		write_reg(REG_LONG, '1);
		write_reg(REG_WINDOW, '1);
		cfg_valid <= 1'b0;
		settings_tried++;
		send_run(1'b0, 2, 0);
		send_run(1'b1, 40, 0);
		send_run(1'b0, 40, 0);
		send_run(1'b1, 3, 0);

		in_valid <= 1'b0;
		for (k = 0; k < 1000 && pending_events.size() != 0; k++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		while (pending_events.size() != 0) begin
			report_mismatch($sformatf("expected event %0d never arrived",
				pending_events.pop_front()));
		end

		$display("Sent %0d ticks under %0d register settings; %0d results checked.",
			ticks_sent, settings_tried, results_seen);
		$display("Events seen: %0d long press, %0d click, %0d double click.",
			tally_long, tally_click, tally_double);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : watchdog
		#(TICK_PERIOD * 2_000_000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
